[rtl/rcd_pkg.sv]
`default_nettype none

package rcd_pkg;

   localparam int BLOCKS_PER_GROUP    = 6;
   localparam int SECOND_TABLE_BLOCKS = 2;

   localparam int DATA_W   = 16;
   localparam int FUNC_W   = 2;
   localparam int COEFF_W  = 16;
   localparam int POS_W    = 6;
   localparam int BLOCK_W  = 3;
   localparam int VALUE_W  = 10;
   localparam int SCALE_W  = 6;
   localparam int QBYTE_W  = 8;

   localparam int TABLE_DEPTH = 128;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [DATA_W-1:0] EOB_CODE = 16'hFE00;
   localparam logic [POS_W-1:0]  LAST_POS = 6'd63;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TABLE = 2'd0,
      FUNC_COEF  = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      KIND_TABLE,
      KIND_COEF,
      KIND_EOB,
      KIND_CLEAR
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [DATA_W-1:0] data;
   } entry_type;

endpackage

`default_nettype wire

[rtl/rle_coefficient_dequantizer.sv]
// Run-length coefficient dequantizer for 8x8 blocks. Each input word carries a function code
// in req_tuser: a quantization table byte (stored at a wrapping index into a 128-entry table,
// upper half used by the first two blocks of each group of six), a coded halfword that is
// expanded into dequantized coefficients, or a clear of the tables and counters. A front end
// classifies words into a two-entry queue and a back-end sequencer executes them in order, so
// table writes and coefficient reads never pass each other. The sequencer issues one output
// word per cycle, unless rsp_tready stalls, for every zero of a run or end-of-block fill; a
// dequantized coefficient passes a table memory read, two registered multiplies and an output
// load, a table byte or clear acts at dispatch, and an output register decouples rsp_tready.
`default_nettype none

module rle_coefficient_dequantizer
   import rcd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [15:0] data
   input  wire logic [1:0]  req_tuser,  // [1:0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // [15:0] coeff, [21:16] position, [24:22] block_number
   output logic             rsp_tlast,
   output logic [0:0]       rsp_tuser   // [0] block_done
);

   entry_type           push_entry;
   entry_type           pop_entry;
   logic                push_valid, push_ready;
   logic                pop_valid, pop_ready;
   logic [COEFF_W-1:0]  coeff;
   logic [POS_W-1:0]    position;
   logic [BLOCK_W-1:0]  block_number;
   logic                block_done;

   rcd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   rcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   rcd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_entry        (pop_entry),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_coeff        (coeff),
      .rsp_position     (position),
      .rsp_block_number (block_number),
      .rsp_last         (rsp_tlast),
      .rsp_block_done   (block_done)
   );

   assign rsp_tdata = {7'b0, block_number, position, coeff};
   assign rsp_tuser = block_done;

endmodule

`default_nettype wire

[rtl/rcd_ram.sv]
`default_nettype none

module rcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/rcd_front.sv]
`default_nettype none

module rcd_front
   import rcd_pkg::*;
(
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,
   input  wire logic [FUNC_W-1:0] req_tuser,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output entry_type              push_entry
);

   always_comb begin
      push_entry.data = req_tdata;
      push_entry.kind = KIND_TABLE;
      push_valid      = req_tvalid;
      case (req_tuser)
         FUNC_TABLE: begin
            push_entry.kind = KIND_TABLE;
         end
         FUNC_COEF: begin
            push_entry.kind = (req_tdata == EOB_CODE) ? KIND_EOB : KIND_COEF;
         end
         FUNC_CLEAR: begin
            push_entry.kind = KIND_CLEAR;
         end
         default: begin
            // An unused function code is taken and dropped here.
            push_valid = 1'b0;
         end
      endcase
   end

   assign req_tready = push_ready;

endmodule

`default_nettype wire

[rtl/rcd_queue.sv]
`default_nettype none

module rcd_queue
   import rcd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output logic           push_ready,
   input  wire entry_type push_entry,
   output logic           pop_valid,
   input  wire logic      pop_ready,
   output entry_type      pop_entry
);

   entry_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff, count_in;
   logic                    do_push, do_pop;

   assign push_ready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[rtl/rcd_back.sv]
`default_nettype none

module rcd_back
   import rcd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   input  wire entry_type          pop_entry,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [COEFF_W-1:0]      rsp_coeff,
   output logic [POS_W-1:0]        rsp_position,
   output logic [BLOCK_W-1:0]      rsp_block_number,
   output logic                    rsp_last,
   output logic                    rsp_block_done
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZERO,
      ST_RD,
      ST_MUL1,
      ST_MUL2,
      ST_EMIT
   } state_type;

   state_type                    state_ff, state_in;
   logic [POS_W-1:0]             pos_ff, pos_in;
   logic [BLOCK_W-1:0]           blk_ff, blk_in;
   logic [SCALE_W-1:0]           scale_ff, scale_in;
   logic [TABLE_AW-1:0]          widx_ff, widx_in;
   logic [TABLE_DEPTH-1:0]       valid_ff, valid_in;
   logic [POS_W-1:0]             run_ff, run_in;
   logic                         eob_ff, eob_in;
   logic                         first_ff, first_in;
   logic signed [VALUE_W-1:0]    val_ff, val_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic signed [VALUE_W+QBYTE_W:0]          m1_ff, m1_in;
   logic signed [VALUE_W+QBYTE_W+SCALE_W+1:0] prod;
   logic [COEFF_W-1:0]           res_ff, res_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [COEFF_W-1:0]           rsp_coeff_ff, rsp_coeff_in;
   logic [POS_W-1:0]             rsp_pos_ff, rsp_pos_in;
   logic [BLOCK_W-1:0]           rsp_blk_ff, rsp_blk_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_done_ff, rsp_done_in;

   logic                         out_free;
   logic                         load;
   logic                         advance;
   logic                         at_end;
   logic                         ram_wr_en;
   logic                         ram_rd_en;
   logic [TABLE_AW-1:0]          ram_rd_addr;
   logic [QBYTE_W-1:0]           ram_rd_data;
   logic [QBYTE_W-1:0]           qbyte;

   rcd_ram #(
      .WIDTH(QBYTE_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (widx_ff),
      .wr_data (pop_entry.data[QBYTE_W-1:0]),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign at_end      = (pos_ff == LAST_POS);
   assign pop_ready   = (state_ff == ST_IDLE);
   assign ram_wr_en   = (state_ff == ST_IDLE) && pop_valid && (pop_entry.kind == KIND_TABLE);
   assign ram_rd_en   = (state_ff == ST_RD);
   // Blocks at the start of each group use the upper table.
   assign ram_rd_addr = {(int'(blk_ff) < SECOND_TABLE_BLOCKS), pos_ff};
   assign qbyte       = rd_valid_ff ? ram_rd_data : '0;
   assign prod        = m1_ff * $signed({1'b0, scale_ff});

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      blk_in       = blk_ff;
      scale_in     = scale_ff;
      widx_in      = widx_ff;
      valid_in     = valid_ff;
      run_in       = run_ff;
      eob_in       = eob_ff;
      first_in     = first_ff;
      val_in       = val_ff;
      rd_valid_in  = rd_valid_ff;
      m1_in        = m1_ff;
      res_in       = res_ff;
      load         = 1'b0;
      advance      = 1'b0;
      rsp_coeff_in = rsp_coeff_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               val_in   = $signed(pop_entry.data[VALUE_W-1:0]);
               run_in   = pop_entry.data[DATA_W-1:VALUE_W];
               eob_in   = 1'b0;
               first_in = 1'b0;
               case (pop_entry.kind)
                  KIND_TABLE: begin
                     valid_in[widx_ff] = 1'b1;
                     widx_in           = widx_ff + 1'b1;
                  end
                  KIND_CLEAR: begin
                     valid_in = '0;
                     widx_in  = '0;
                     scale_in = '0;
                     pos_in   = '0;
                     blk_in   = '0;
                  end
                  KIND_EOB: begin
                     eob_in   = 1'b1;
                     state_in = ST_ZERO;
                     if (pos_ff == '0) begin
                        scale_in = '0;
                     end
                  end
                  KIND_COEF: begin
                     if (pos_ff == '0) begin
                        first_in = 1'b1;
                        scale_in = pop_entry.data[DATA_W-1:VALUE_W];
                        state_in = ST_RD;
                     end else if (pop_entry.data[DATA_W-1:VALUE_W] != '0) begin
                        state_in = ST_ZERO;
                     end else begin
                        state_in = ST_RD;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               load         = 1'b1;
               advance      = 1'b1;
               rsp_coeff_in = '0;
               rsp_last_in  = at_end;
               if (at_end) begin
                  state_in = ST_IDLE;
               end else if (!eob_ff) begin
                  run_in = run_ff - 1'b1;
                  if (run_ff == POS_W'(1)) begin
                     state_in = ST_RD;
                  end
               end
            end
         end
         ST_RD: begin
            rd_valid_in = valid_ff[ram_rd_addr];
            state_in    = ST_MUL1;
         end
         ST_MUL1: begin
            m1_in    = val_ff * $signed({1'b0, qbyte});
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            // The shift by four on a two's complement product rounds toward minus infinity.
            res_in   = first_ff ? m1_ff[COEFF_W-1:0] : prod[COEFF_W+3:4];
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               load         = 1'b1;
               advance      = 1'b1;
               rsp_coeff_in = res_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_pos_in  = load ? pos_ff : rsp_pos_ff;
      rsp_blk_in  = load ? blk_ff : rsp_blk_ff;
      rsp_done_in = load ? at_end : rsp_done_ff;

      if (advance) begin
         if (at_end) begin
            pos_in = '0;
            blk_in = (blk_ff == BLOCK_W'(BLOCKS_PER_GROUP-1)) ? '0 : blk_ff + 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         blk_ff       <= '0;
         scale_ff     <= '0;
         widx_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         blk_ff       <= blk_in;
         scale_ff     <= scale_in;
         widx_ff      <= widx_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      run_ff       <= run_in;
      eob_ff       <= eob_in;
      first_ff     <= first_in;
      val_ff       <= val_in;
      rd_valid_ff  <= rd_valid_in;
      m1_ff        <= m1_in;
      res_ff       <= res_in;
      rsp_coeff_ff <= rsp_coeff_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_blk_ff   <= rsp_blk_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_coeff        = rsp_coeff_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_block_number = rsp_blk_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_block_done   = rsp_done_ff;

   a_blk_range: assert property (@(posedge clock) disable iff (reset)
      int'(blk_ff) < BLOCKS_PER_GROUP)
      else $error("Block counter left the group range.");

   a_zero_run_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ZERO && !eob_ff) |-> (run_ff != '0))
      else $error("Zero run entered with nothing left to emit.");

   a_mid_word_busy: assert property (@(posedge clock) disable iff (reset)
      (load && !rsp_last_in) |=> (state_ff != ST_IDLE))
      else $error("Sequencer went idle before the last coefficient of a word.");

   a_mul_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL1) |-> ($past(state_ff) == ST_RD))
      else $error("Multiply stage entered without a table read.");

endmodule

`default_nettype wire

[tb/sv/tb_rle_coefficient_dequantizer.sv]
`timescale 1ns / 100ps

module tb_rle_coefficient_dequantizer;
   import rcd_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int WORD_COUNT  = 450;
   localparam int STEADY_FROM = 2000;
   localparam int STEADY_TO   = 5000;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [DATA_W-1:0] data;
   } req_word_type;

   typedef struct {
      logic [COEFF_W-1:0] coeff;
      logic [POS_W-1:0]   position;
      logic [BLOCK_W-1:0] block_number;
      logic               last_of_run;
      logic               block_done;
   } coeff_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic rsp_tlast;
   logic [0:0] rsp_tuser;

   req_word_type pending_words[$];
   coeff_result_type coeff_expected[$];

   logic [QBYTE_W-1:0]  quant_store[TABLE_DEPTH];
   logic [TABLE_AW-1:0] store_index = '0;
   logic [SCALE_W-1:0]  scale_now = '0;
   logic [POS_W-1:0]    coef_pos = '0;
   logic [BLOCK_W-1:0]  block_idx = '0;

   int cycle = 0;
   int words_queued = 0;
   int words_sent = 0;
   int coeffs_checked = 0;
   int blocks_done = 0;
   int mismatches = 0;

   rle_coefficient_dequantizer dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle <= cycle + 1;
   end

   function automatic bit take_break();
      if (cycle >= STEADY_FROM && cycle < STEADY_TO) begin
         return 1'b0;
      end
      return $urandom_range(0, 99) < 36;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < 30) begin
         $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      end
      mismatches++;
   endtask

   task automatic clear_state();
      foreach (quant_store[i]) begin
         quant_store[i] = '0;
      end
      store_index = '0;
      scale_now = '0;
      coef_pos = '0;
      block_idx = '0;
   endtask

   task automatic put_coeff(input int value);
      coeff_result_type r;
      r.coeff = value[COEFF_W-1:0];
      r.position = coef_pos;
      r.block_number = block_idx;
      r.last_of_run = 1'b0;
      r.block_done = (coef_pos == LAST_POS);
      coeff_expected.push_back(r);
      if (coef_pos == LAST_POS) begin
         coef_pos = '0;
         block_idx = block_idx + 1'b1;
         if (block_idx >= BLOCKS_PER_GROUP) begin
            block_idx = '0;
         end
      end else begin
         coef_pos = coef_pos + 1'b1;
      end
   endtask

   task automatic dequantize_word(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] data);
      int base;
      int value;
      int product;
      int run;
      int first;
      bit room;
      first = coeff_expected.size();
      case (func)
         FUNC_TABLE: begin
            quant_store[store_index] = data[QBYTE_W-1:0];
            store_index = store_index + 1'b1;
         end
         FUNC_CLEAR: begin
            clear_state();
         end
         FUNC_COEF: begin
            base = (block_idx < SECOND_TABLE_BLOCKS) ? 64 : 0;
            value = int'($signed(data[VALUE_W-1:0]));
            run = int'(data[DATA_W-1:VALUE_W]);
            if (data == EOB_CODE) begin
               if (coef_pos == 0) begin
                  scale_now = '0;
               end
               do begin
                  put_coeff(0);
               end while (coef_pos != 0);
            end else if (coef_pos == 0) begin
               scale_now = data[DATA_W-1:VALUE_W];
               put_coeff(value * int'(quant_store[base]));
            end else begin
               room = 1'b1;
               for (int k = 0; k < run; k++) begin
                  put_coeff(0);
                  if (coef_pos == 0) begin
                     room = 1'b0;
                     break;
                  end
               end
               if (room) begin
                  product = value * int'(scale_now)
                            * int'(quant_store[TABLE_AW'(base + int'(coef_pos))]);
                  put_coeff(product >>> 4);
               end
            end
         end
         default: begin
         end
      endcase
      if (coeff_expected.size() > first) begin
         coeff_expected[coeff_expected.size() - 1].last_of_run = 1'b1;
      end
   endtask

   always @(posedge clock) begin : drive
      req_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            dequantize_word(req_tuser, req_tdata);
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() > 0 && !take_break()) begin
               w = pending_words.pop_front();
               req_tuser <= w.func;
               req_tdata <= w.data;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch
      coeff_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (coeff_expected.size() == 0) begin
               report_mismatch("coefficient with nothing outstanding",
                               int'($signed(rsp_tdata[15:0])), 0);
            end else begin
               want = coeff_expected.pop_front();
               coeffs_checked++;
               if (rsp_tdata[15:0] !== want.coeff) begin
                  report_mismatch("coeff", int'($signed(rsp_tdata[15:0])),
                                  int'($signed(want.coeff)));
               end
               if (rsp_tdata[21:16] !== want.position) begin
                  report_mismatch("position", int'(rsp_tdata[21:16]), int'(want.position));
               end
               if (rsp_tdata[24:22] !== want.block_number) begin
                  report_mismatch("block_number", int'(rsp_tdata[24:22]),
                                  int'(want.block_number));
               end
               if (rsp_tlast !== want.last_of_run) begin
                  report_mismatch("last_of_run", int'(rsp_tlast), int'(want.last_of_run));
               end
               if (rsp_tuser[0] !== want.block_done) begin
                  report_mismatch("block_done", int'(rsp_tuser[0]), int'(want.block_done));
               end
               if (want.block_done) begin
                  blocks_done++;
               end
            end
         end
         rsp_tready <= !take_break();
      end
   end

   function automatic logic [DATA_W-1:0] coded(input int run, input int value);
      return {run[SCALE_W-1:0], value[VALUE_W-1:0]};
   endfunction

   function automatic int pick_value();
      case ($urandom_range(0, 5))
         0: return -512;
         1: return 511;
         default: return $urandom_range(0, 1023);
      endcase
   endfunction

   task automatic queue_word(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] data);
      req_word_type w;
      w.func = func;
      w.data = data;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic load_tables(input int count, input bit pin_corners);
      logic [7:0] b;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 7))
            0: b = 8'hFF;
            1: b = 8'h00;
            default: b = 8'($urandom_range(0, 255));
         endcase
         if (pin_corners && (i == 0 || i == 64)) begin
            b = 8'hFF;
         end
         queue_word(FUNC_TABLE, {8'($urandom_range(0, 255)), b});
      end
   endtask

   task automatic queue_block();
      int next_pos;
      int ac_count;
      int run;
      queue_word(FUNC_COEF, coded($urandom_range(0, 63), pick_value()));
      next_pos = 1;
      ac_count = $urandom_range(0, 12);
      for (int k = 0; k < ac_count && next_pos < 64; k++) begin
         case ($urandom_range(0, 9))
            0: run = $urandom_range(16, 63);
            1, 2: run = $urandom_range(4, 15);
            default: run = $urandom_range(0, 3);
         endcase
         queue_word(FUNC_COEF, coded(run, pick_value()));
         next_pos += run + 1;
      end
      if (next_pos < 64 && $urandom_range(0, 9) != 0) begin
         queue_word(FUNC_COEF, EOB_CODE);
      end
   endtask

   initial begin
      int pick;
      clear_state();

      queue_word(FUNC_UNUSED, 16'hFFFF);
      load_tables(TABLE_DEPTH, 1'b1);
      queue_word(FUNC_COEF, EOB_CODE);
      queue_word(FUNC_COEF, coded(63, 511));
      queue_word(FUNC_COEF, coded(0, -512));
      queue_word(FUNC_COEF, coded(63, 1));
      queue_word(FUNC_COEF, coded(0, -512));
      queue_word(FUNC_COEF, coded(62, 1));
      queue_word(FUNC_COEF, coded(0, -1));
      queue_word(FUNC_COEF, coded(0, 1));
      queue_word(FUNC_COEF, EOB_CODE);
      queue_word(FUNC_COEF, coded(32, 300));
      queue_word(FUNC_CLEAR, 16'hFFFF);
      queue_word(FUNC_COEF, coded(31, -7));
      queue_word(FUNC_COEF, EOB_CODE);
      queue_word(FUNC_UNUSED, 16'h0000);
      load_tables(TABLE_DEPTH, 1'b0);

      while (words_queued < WORD_COUNT) begin
         pick = $urandom_range(0, 99);
         if (pick < 84) begin
            queue_block();
         end else if (pick < 92) begin
            load_tables($urandom_range(1, 8), 1'b0);
         end else if (pick < 98) begin
            queue_word(FUNC_W'($urandom_range(0, 3)), DATA_W'($urandom_range(0, 65535)));
         end else begin
            queue_word(FUNC_CLEAR, DATA_W'($urandom_range(0, 65535)));
            load_tables($urandom_range(16, 64), 1'b0);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (pending_words.size() == 0 && words_sent == words_queued);
      wait (coeff_expected.size() == 0);
      repeat (100) @(posedge clock);

      $display("Sent %0d words; checked %0d coefficients covering %0d complete blocks.",
               words_sent, coeffs_checked, blocks_done);
      $display("Field mismatches counted: %0d.", mismatches);
      if (mismatches == 0 && coeff_expected.size() == 0) begin
         $display("rle_coefficient_dequantizer: match");
      end else begin
         $display("rle_coefficient_dequantizer: mismatch");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Timed out with %0d words sent and %0d coefficients outstanding.",
               words_sent, coeff_expected.size());
      $display("rle_coefficient_dequantizer: mismatch");
      $finish;
   end

endmodule

[rle_coefficient_dequantizer.f]
rtl/rcd_pkg.sv
rtl/rcd_ram.sv
rtl/rcd_front.sv
rtl/rcd_queue.sv
rtl/rcd_back.sv
rtl/rle_coefficient_dequantizer.sv
tb/sv/tb_rle_coefficient_dequantizer.sv
